// ===== design/pfbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power float BCD codec package
// Word types of both channels, the internal pipeline word and the constants
// shared by the stages.
// ----------------------------------------------------------------------------
package pfbc_pkg;

    // Direction codes carried in the mode field.
    localparam logic MODE_DECODE = 1'b0;
    localparam logic MODE_ENCODE = 1'b1;

    // Exponent codes with a fixed meaning.
    localparam logic [2:0] EXP_DIV_TEN = 3'd7;
    localparam logic [2:0] EXP_WHOLE   = 3'd4;
    localparam logic [2:0] EXP_MAX_DIV = 3'd6;

    localparam logic [31:0] DIGIT_LIMIT  = 32'd1000;
    localparam logic [9:0]  DIGIT_SAT    = 10'd999;
    localparam logic [31:0] WHOLE_LIMIT  = 32'd99900;

    // Reciprocals used in place of dividers.
    localparam logic [63:0] RECIP_TEN_32 = 64'h0000_0000_CCCC_CCCD; // x/10 = (x*r)>>35
    localparam logic [23:0] RECIP_TEN_11 = 24'd6554;                // x/10 = (x*r)>>16
    localparam logic [40:0] RECIP_HUND   = 41'd167773;              // x/100 = (x*r)>>24
    localparam logic [23:0] HUND_FRAC    = 24'd167772;              // exact multiple below this

    typedef struct packed {
        logic              mode;
        logic [15:0]       packed_in;
        logic signed [31:0] power_in;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] power_out;
        logic [15:0]       packed_out;
    } t_out_word;

    // Word that travels down the pipeline; each stage fills in its own fields.
    typedef struct packed {
        logic        mode;
        logic        neg;
        logic [2:0]  dec_g;
        logic [10:0] dec_sum;
        logic [31:0] val;
        logic        enc_lt;
        logic [2:0]  enc_n;
        logic        enc_whole;
        logic [9:0]  enc_q;
        logic [2:0]  enc_g;
        logic [9:0]  digit;
        logic [3:0]  hund;
        logic [6:0]  rem;
        logic [15:0] word;
    } t_work;

    // Scale factor 10^(6-g) for exponents 0 to 6.
    function automatic logic [19:0] pfbc_pow10(input logic [2:0] g);
        logic [19:0] p;
        unique case (g)
            3'd0:    p = 20'd1000000;
            3'd1:    p = 20'd100000;
            3'd2:    p = 20'd10000;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd100;
            3'd5:    p = 20'd10;
            default: p = 20'd1;
        endcase
        return p;
    endfunction

endpackage

// ===== design/pfbc_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipeline stage register
// Holds one pipeline word with its valid bit and passes back-pressure up.
// ----------------------------------------------------------------------------
module pfbc_stage
    import pfbc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_work i_work,
    output logic  o_valid,
    input  logic  i_ready,
    output t_work o_work
);

    logic  r_valid;
    t_work r_work;

    // The stage can load whenever it is empty or its word leaves this cycle.
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_work  = r_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_work <= i_work;
        end
    end

endmodule

// ===== design/pfbc_div_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encode division step
// Cuts an encode magnitude by one decimal place while it has four or more
// digits, counting the places removed.
// ----------------------------------------------------------------------------
module pfbc_div_step
    import pfbc_pkg::*;
(
    input  t_work i_work,
    output t_work o_work
);

    logic [63:0] w_prod;

    assign w_prod = 64'(i_work.val) * RECIP_TEN_32;

    always_comb begin
        o_work = i_work;
        if (i_work.mode == MODE_ENCODE && i_work.val >= DIGIT_LIMIT) begin
            o_work.val   = 32'(w_prod[63:35]);
            o_work.enc_n = i_work.enc_n + 3'd1;
        end
    end

endmodule

// ===== design/power_float_bcd_codec_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power float BCD codec
// Converts between signed power in 0.01 kW units and the packed three-digit
// BCD word with sign and decimal exponent, in either direction.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: i_valid, o_ready and i_data. A word is taken at a rising
//   edge where i_valid and o_ready are both high. Bit mode selects decode of
//   packed_in (0) or encode of power_in (1); the unused result field is zero.
//   Output channel: o_valid, i_ready and o_data, one result for every input.
//   A word passes through all ten register stages before its result shows
//   on o_valid. Each stage has its own valid bit, so while the receiver
//   keeps i_ready high a new word can enter in every cycle and the
//   sustained rate is one word per cycle. What sets the depth is the
//   encode path: six stages each divide the magnitude by ten while it has
//   four or more digits, with one 32 by 32 reciprocal multiply.
//   When the receiver holds i_ready low, words stay in their stages and the
//   pipeline fills up; o_ready drops only once all ten stages hold a word,
//   so nothing is lost or repeated.
//   Reset (synchronous, active low) empties every stage; no state other
//   than the valid bits is kept.
// ----------------------------------------------------------------------------
module power_float_bcd_codec_unit
    import pfbc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);

    localparam int NUM_STAGES = 10;

    t_work w_in  [1:NUM_STAGES];
    t_work w_q   [1:NUM_STAGES];
    logic  w_vld [0:NUM_STAGES];
    logic  w_rdy [0:NUM_STAGES];

    assign w_vld[0]          = i_valid;
    assign o_ready           = w_rdy[0];
    assign w_rdy[NUM_STAGES] = i_ready;
    assign o_valid           = w_vld[NUM_STAGES];

    // Stage registers; the word moves on whenever the next stage can take it.
    for (genvar k = 1; k <= NUM_STAGES; k++) begin : g_stage
        pfbc_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[k-1]),
            .o_ready (w_rdy[k-1]),
            .i_work  (w_in[k]),
            .o_valid (w_vld[k]),
            .i_ready (w_rdy[k]),
            .o_work  (w_q[k])
        );
    end

    // Stage one: unpack the word to decode and take the magnitude to encode.
    logic [31:0] w_pin;
    logic [31:0] w_mag;

    assign w_pin = i_data.power_in;
    assign w_mag = w_pin[31] ? (32'd0 - w_pin) : w_pin;

    always_comb begin
        w_in[1]      = '0;
        w_in[1].mode = i_data.mode;
        if (i_data.mode == MODE_DECODE) begin
            // Nibbles count at their binary weight even when they are not BCD.
            w_in[1].neg     = i_data.packed_in[12];
            w_in[1].dec_g   = i_data.packed_in[15:13];
            w_in[1].dec_sum = 11'(i_data.packed_in[11:8]) * 11'd100
                            + 11'(i_data.packed_in[7:4]) * 11'd10
                            + 11'(i_data.packed_in[3:0]);
        end else begin
            w_in[1].neg    = w_pin[31];
            w_in[1].val    = w_mag;
            w_in[1].enc_lt = (w_mag < WHOLE_LIMIT);
        end
    end

    // Stage two: scale the decoded digits, and test for whole hundreds.
    logic [31:0] w_scaled;
    logic [23:0] w_tenth;
    logic [40:0] w_hprod;

    assign w_scaled = 32'(w_q[1].dec_sum) * 32'(pfbc_pow10(w_q[1].dec_g));
    assign w_tenth  = 24'(w_q[1].dec_sum) * RECIP_TEN_11;
    assign w_hprod  = 41'(w_q[1].val[16:0]) * RECIP_HUND;

    always_comb begin
        w_in[2] = w_q[1];
        if (w_q[1].mode == MODE_DECODE) begin
            if (w_q[1].dec_g == EXP_DIV_TEN) begin
                w_in[2].val = 32'(w_tenth[23:16]);
            end else begin
                w_in[2].val = w_scaled;
            end
        end else begin
            // A small low part of the reciprocal product means no remainder.
            w_in[2].enc_whole = w_q[1].enc_lt && (w_hprod[23:0] < HUND_FRAC);
            w_in[2].enc_q     = w_hprod[33:24];
        end
    end

    // Stages three to eight: one decimal place removed per stage at most.
    for (genvar k = 3; k <= 8; k++) begin : g_div
        pfbc_div_step u_div (
            .i_work (w_q[k-1]),
            .o_work (w_in[k])
        );
    end

    // Stage nine: choose the three digits and the exponent, split off hundreds.
    logic [9:0] w_digit;

    always_comb begin
        if (w_q[8].enc_whole) begin
            w_digit = w_q[8].enc_q;
        end else if (w_q[8].val >= DIGIT_LIMIT) begin
            w_digit = DIGIT_SAT;
        end else begin
            w_digit = w_q[8].val[9:0];
        end
    end

    always_comb begin
        logic [3:0] h;
        logic [9:0] base;
        h    = 4'd0;
        base = 10'd0;
        for (int k = 1; k <= 9; k++) begin
            if (w_digit >= 10'(k * 100)) begin
                h    = 4'(k);
                base = 10'(k * 100);
            end
        end
        w_in[9]       = w_q[8];
        w_in[9].digit = w_digit;
        w_in[9].hund  = h;
        w_in[9].rem   = 7'(w_digit - base);
        w_in[9].enc_g = w_q[8].enc_whole ? EXP_WHOLE : (EXP_MAX_DIV - w_q[8].enc_n);
    end

    // Stage ten: tens and units for encode, sign for decode, and the result.
    always_comb begin
        logic [3:0] t;
        logic [6:0] base;
        t    = 4'd0;
        base = 7'd0;
        for (int k = 1; k <= 9; k++) begin
            if (w_q[9].rem >= 7'(k * 10)) begin
                t    = 4'(k);
                base = 7'(k * 10);
            end
        end
        w_in[10] = w_q[9];
        if (w_q[9].mode == MODE_DECODE) begin
            w_in[10].val  = w_q[9].neg ? (32'd0 - w_q[9].val) : w_q[9].val;
            w_in[10].word = 16'd0;
        end else begin
            w_in[10].val  = 32'd0;
            w_in[10].word = {w_q[9].enc_g, w_q[9].neg, w_q[9].hund, t,
                             4'(w_q[9].rem - base)};
        end
    end

    assign o_data.power_out  = w_q[NUM_STAGES].val;
    assign o_data.packed_out = w_q[NUM_STAGES].word;

endmodule

// ===== design/pfbc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power float BCD codec checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pfbc_port_props
    import pfbc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_word o_data
);

    // A result held back by the receiver stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Only one direction's field can be non-zero in a result.
    a_one_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.power_out == 32'sd0 || o_data.packed_out == 16'd0))
        else $error("both result fields non-zero");

    // Encoded digits are always proper BCD.
    a_bcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.packed_out[11:8] <= 4'd9 && o_data.packed_out[7:4] <= 4'd9
                     && o_data.packed_out[3:0] <= 4'd9))
        else $error("encoded digit out of range");

    // Decoded power never exceeds the largest digit sum at full scale.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.power_out <= 32'sd1665000000
                     && o_data.power_out >= -32'sd1665000000))
        else $error("decoded power out of range");

endmodule

bind power_float_bcd_codec_unit pfbc_port_props u_pfbc_port_props (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

// ===== test/pfbc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power float BCD codec checker
// Watches both channels of the codec, works out the expected result for each
// accepted input word and compares every result word against it, field by
// field, in order.
// ----------------------------------------------------------------------------
module pfbc_checker
    import pfbc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_word i_out_word,
    output int        o_fail_count,
    output int        o_pending
);

    t_out_word awaited_q[$];
    t_out_word head;
    int        fail_total = 0;

    assign o_fail_count = fail_total;

    // Three BCD digits of a value below one thousand.
    function automatic logic [11:0] digits_bcd(input logic [9:0] d);
        logic [9:0] h;
        logic [9:0] t;
        logic [9:0] u;
        h = d / 10'd100;
        t = (d / 10'd10) % 10'd10;
        u = d % 10'd10;
        return {h[3:0], t[3:0], u[3:0]};
    endfunction

    // Packed word to power; nibbles count at their binary weight.
    function automatic logic signed [31:0] decoded_power(input logic [15:0] pw);
        logic [2:0]  g;
        logic [31:0] mag;
        int          k;
        g   = pw[15:13];
        mag = 32'(pw[11:8]) * 32'd100 + 32'(pw[7:4]) * 32'd10 + 32'(pw[3:0]);
        if (g == EXP_DIV_TEN) begin
            mag = mag / 32'd10;
        end else begin
            for (k = 0; k < 6 - int'(g); k++) mag = mag * 32'd10;
        end
        if (pw[12]) mag = 32'd0 - mag;
        return signed'(mag);
    endfunction

    // Power to packed word, truncating the digits divided away and saturating at 999.
    function automatic logic [15:0] encoded_word(input logic signed [31:0] p);
        logic        neg;
        logic [31:0] mag;
        logic [2:0]  g;
        int          divs;
        neg = p[31];
        mag = neg ? (32'd0 - unsigned'(p)) : unsigned'(p);
        if (mag < WHOLE_LIMIT && (mag % 32'd100) == 32'd0)
            return {EXP_WHOLE, neg, digits_bcd(10'(mag / 32'd100))};
        divs = 0;
        while (divs < 6 && mag >= DIGIT_LIMIT) begin
            mag = mag / 32'd10;
            divs++;
        end
        if (mag >= DIGIT_LIMIT) mag = 32'(DIGIT_SAT);
        g = EXP_MAX_DIV - 3'(divs);
        return {g, neg, digits_bcd(mag[9:0])};
    endfunction

    function automatic t_out_word codec_result(input t_in_word w);
        t_out_word r;
        if (w.mode == MODE_DECODE) begin
            r.power_out  = decoded_power(w.packed_in);
            r.packed_out = '0;
        end else begin
            r.power_out  = '0;
            r.packed_out = encoded_word(w.power_in);
        end
        return r;
    endfunction

    task automatic note_failure(input string what, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
        if (fail_total < 10)
            $display("%0t: %s wrong, expected %h, got %h", $time, what, exp_v, act_v);
        fail_total++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            awaited_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_q.size() == 0) begin
                    note_failure("unexpected result word", '0, i_out_word.power_out);
                end else begin
                    head = awaited_q.pop_front();
                    if (head.power_out !== i_out_word.power_out)
                        note_failure("power_out", head.power_out, i_out_word.power_out);
                    if (head.packed_out !== i_out_word.packed_out)
                        note_failure("packed_out", 32'(head.packed_out),
                                     32'(i_out_word.packed_out));
                end
            end
            if (i_in_valid && i_in_ready)
                awaited_q.push_back(codec_result(i_in_word));
        end
        o_pending <= awaited_q.size();
    end

endmodule

// ===== test/tb_power_float_bcd_codec_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power float BCD codec testbench
// Drives directed and random decode and encode words into the codec with
// random idling on both channels, and leaves the checking to pfbc_checker.
// ----------------------------------------------------------------------------
module tb_power_float_bcd_codec_unit;
    import pfbc_pkg::*;

    // Cycle budget: about 725 words, each at worst with the longest sender gap,
    // the longest receiver stall and the ten-stage pipeline, plus the
    // opening hold-off. The limit is far above that total.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 700;
    localparam int CALM_ITEMS   = 100;   // final words with no idling at all
    localparam int HOLD_CYCLES  = 120;   // receiver hold-off after reset
    localparam int DRAIN_CYCLES = 30;    // beyond the ten-stage pipeline

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;
    int        fail_count;
    int        pending;
    bit        calm       = 1'b0;
    int        gap_chance = 0;   // one word in gap_chance is preceded by a gap
    int        cycles     = 0;

    power_float_bcd_codec_unit u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_data  (in_word),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_data  (out_word)
    );

    pfbc_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // A decode word; the unused power field carries random bits so that
    // every input bit is exercised in both modes.
    function automatic t_in_word dec_item(input logic [15:0] pw);
        t_in_word w;
        w.mode      = MODE_DECODE;
        w.packed_in = pw;
        w.power_in  = $urandom;
        return w;
    endfunction

    function automatic t_in_word enc_item(input logic signed [31:0] p);
        t_in_word w;
        w.mode      = MODE_ENCODE;
        w.packed_in = 16'($urandom);
        w.power_in  = p;
        return w;
    endfunction

    // Random word. Decode takes either raw bits or proper BCD digits; encode
    // leans towards magnitudes around the digit and exponent boundaries.
    function automatic t_in_word random_item();
        t_in_word    w;
        logic [31:0] mag;
        logic [31:0] p10;
        int          k;
        if ($urandom_range(0, 1) == 0) begin
            w = dec_item(16'($urandom));
            if ($urandom_range(0, 1) == 1)
                w.packed_in[11:0] = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                                     4'($urandom_range(0, 9))};
        end else begin
            p10 = 32'd1;
            k   = $urandom_range(1, 9);
            repeat (k) p10 = p10 * 32'd10;
            case ($urandom_range(0, 4))
                0:       mag = $urandom;
                1:       mag = $urandom_range(0, 2000);
                2:       mag = 32'd100 * $urandom_range(0, 1000);
                3:       mag = $urandom % p10;
                default: mag = p10 + $urandom_range(0, 2) - 32'd1;
            endcase
            w = enc_item($urandom_range(0, 1) ? signed'(32'd0 - mag) : signed'(mag));
        end
        return w;
    endfunction

    // Offers one word and returns at the edge where it is taken. Valid stays
    // high afterwards so that back-to-back words need no extra edge.
    task automatic send_word(input t_in_word w);
        if (!calm && gap_chance != 0 && $urandom_range(1, gap_chance) == 1) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
    endtask

    // Receiver. It first holds off for a long stretch while the directed
    // words are offered, so the pipeline fills and the input stalls. After
    // that it mixes short stalls with long stretches of steady readiness,
    // and in the closing part of the run it takes every word at once.
    initial begin : receiver
        int pick;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        repeat (HOLD_CYCLES) @(posedge clk);
        forever begin
            if (calm) begin
                out_ready <= 1'b1;
                @(posedge clk);
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 2) begin
                    out_ready <= 1'b1;
                    repeat ($urandom_range(20, 80)) @(posedge clk);
                end else if (pick < 5) begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(1, 11)) @(posedge clk);
                end else begin
                    out_ready <= 1'b1;
                    @(posedge clk);
                end
            end
        end
    end

    initial begin : stimulus
        int i;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed decode words: zero with either sign, the largest proper
        // BCD value, the exponent that divides by ten, all-ones nibbles
        // at both ends of the exponent range, and exponents 1, 3, 4, 5 and 6 once.
        send_word(dec_item(16'h0000));
        send_word(dec_item(16'h1000));
        send_word(dec_item(16'h0999));
        send_word(dec_item(16'hE999));
        send_word(dec_item(16'hFFFF));
        send_word(dec_item(16'h0FFF));
        send_word(dec_item(16'h1FFF));
        send_word(dec_item(16'hC123));
        send_word(dec_item(16'hAABC));
        send_word(dec_item(16'h9456));
        send_word(dec_item(16'h2555));
        send_word(dec_item(16'h7321));

        // Directed encode words: whole hundreds including zero and the
        // largest one below the limit, the limit itself, the three-digit
        // edge, saturation from one thousand million upwards, and the most
        // negative value.
        send_word(enc_item(32'sd0));
        send_word(enc_item(32'sd100));
        send_word(enc_item(32'sd99800));
        send_word(enc_item(32'sd99900));
        send_word(enc_item(32'sd999));
        send_word(enc_item(32'sd1000));
        send_word(enc_item(-32'sd1));
        send_word(enc_item(-32'sd100));
        send_word(enc_item(32'sd123456789));
        send_word(enc_item(32'sd999999999));
        send_word(enc_item(32'sd1000000000));
        send_word(enc_item(32'sh7FFF_FFFF));
        send_word(enc_item(32'sh8000_0000));

        // Random words. The sender's gap rate changes every fifty words,
        // including stretches with no gaps at all.
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0:       gap_chance = 0;
                    1:       gap_chance = 3;
                    default: gap_chance = 8;
                endcase
            end
            if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            send_word(random_item());
        end
        in_valid <= 1'b0;

        // Let the last accepted word reach the checker, then drain.
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
